// ===== design/uartf_pkg.sv =====
// ----------------------------------------------------------------------------
// uartf_pkg
// Shared types and constants of the 8N1 transmitter with its byte queue.
// ----------------------------------------------------------------------------
package uartf_pkg;

  // Item kinds on the input channel.
  localparam logic ModePush = 1'b0;
  localparam logic ModeTick = 1'b1;

  // Bit times that follow the start bit: eight data bits and the stop bit.
  localparam logic [3:0] FrameBitsAfterStart = 4'd9;

  // Line levels.
  localparam logic LineIdle  = 1'b1;
  localparam logic LineStart = 1'b0;

  // Occupancy flags of the byte queue.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// ===== design/uartf_if.sv =====
// ----------------------------------------------------------------------------
// uartf_if
// Valid/ready channels of the transmitter: input items and result items.
// ----------------------------------------------------------------------------
interface uartf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface uartf_out_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic push_accepted;
  logic fifo_full;
  logic busy_res;

  modport source (output valid, output tx_line, output push_accepted,
                  output fifo_full, output busy_res, input ready);
  modport sink   (input valid, input tx_line, input push_accepted,
                  input fifo_full, input busy_res, output ready);
endinterface

// ===== design/uartf_fifo.sv =====
// ----------------------------------------------------------------------------
// uartf_fifo
// Ring buffer of complemented bytes with one slot kept free, a single write
// port and a registered read port.
// ----------------------------------------------------------------------------
module uartf_fifo
  import uartf_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_i,
  input  logic       pop_i,
  output logic       push_done_o,
  output logic       pop_done_o,
  output fifo_stat_t stat_next_o,
  output logic [7:0] rd_data_o
);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] wr_q, wr_d;
  logic [IdxW-1:0] rd_q, rd_d;
  fifo_stat_t      stat;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(Depth - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign stat.empty = (wr_q == rd_q);
  assign stat.full  = (next_slot(wr_q) == rd_q);

  assign push_done_o = push_i && !stat.full;
  assign pop_done_o  = pop_i && !stat.empty;

  assign wr_d = push_done_o ? next_slot(wr_q) : wr_q;
  assign rd_d = pop_done_o ? next_slot(rd_q) : rd_q;

  assign stat_next_o.empty = (wr_d == rd_d);
  assign stat_next_o.full  = (next_slot(wr_d) == rd_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  // Bytes are kept complemented so that the zeros shifted in behind the
  // data turn into the stop bit.
  always_ff @(posedge clk_i) begin
    if (push_done_o) begin
      mem_q[wr_q] <= ~data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_done_o) begin
      rd_data_q <= mem_q[rd_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/uart_transmitter_with_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_transmitter_with_fifo
// 8N1 serial transmitter fed by a ring buffer of FIFO_DEPTH-1 bytes.
// ----------------------------------------------------------------------------
// Usage: every item on in_i is either a push (mode 0), which offers data_byte
// to the queue, or a tick (mode 1), which advances the serial line by one bit
// time. A frame is a start bit, eight data bits LSB first and a stop bit.
// Each item gives exactly one result on out_o: the line level, whether the
// push entered the queue, and the full and busy flags after the item.
// The result is registered at the edge that accepts the item. Throughput is one
// item per cycle while out_o takes the results; the queue memory has one write
// and one registered read port, and the read of a frame's byte overlaps the
// start bit, so it never holds off an item.
// A result that waits on a stalled receiver is held, and in_i.ready stays
// high as long as that result is taken in the same cycle; otherwise the
// block holds off further items until out_o.ready returns.
// Reset empties the queue, ends any frame and drives the line high.
// ----------------------------------------------------------------------------
module uart_transmitter_with_fifo
  import uartf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uartf_in_if.sink    in_i,
  uartf_out_if.source out_o
);

  logic       accept;
  logic       is_push;
  logic       is_tick;
  logic       frame_idle;
  logic       push_done;
  logic       pop_done;
  fifo_stat_t stat_next;
  logic [7:0] rd_data;
  logic [7:0] shift_eff;

  logic [7:0] shift_q, shift_d;
  logic [3:0] bits_q, bits_d;
  logic       line_q, line_d;
  logic       load_q, load_d;
  logic       out_valid_q, out_valid_d;
  logic       tx_line_q, accepted_q, full_q, busy_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_push    = accept && (in_i.mode == ModePush);
  assign is_tick    = accept && (in_i.mode == ModeTick);
  assign frame_idle = (bits_q == '0);

  uartf_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (is_push),
    .data_i     (in_i.data_byte),
    .pop_i      (is_tick && frame_idle),
    .push_done_o(push_done),
    .pop_done_o (pop_done),
    .stat_next_o(stat_next),
    .rd_data_o  (rd_data)
  );

  // Right after a frame starts, the byte sits in the read register of the
  // queue rather than in the shifter.
  assign shift_eff = load_q ? rd_data : shift_q;

  always_comb begin
    shift_d = shift_q;
    bits_d  = bits_q;
    line_d  = line_q;
    load_d  = load_q;
    if (is_tick && !frame_idle) begin
      bits_d  = bits_q - 1'b1;
      line_d  = ~shift_eff[0];
      shift_d = {1'b0, shift_eff[7:1]};
      load_d  = 1'b0;
    end else if (pop_done) begin
      bits_d = FrameBitsAfterStart;
      line_d = LineStart;
      load_d = 1'b1;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bits_q      <= '0;
      line_q      <= LineIdle;
      load_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      line_q      <= line_d;
      load_q      <= load_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_line_q  <= line_d;
      accepted_q <= push_done;
      full_q     <= stat_next.full;
      busy_q     <= (bits_d != '0) || !stat_next.empty;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.tx_line       = tx_line_q;
  assign out_o.push_accepted = accepted_q;
  assign out_o.fifo_full     = full_q;
  assign out_o.busy_res      = busy_q;

endmodule

// ===== design/uartf_checker.sv =====
// ----------------------------------------------------------------------------
// uartf_checker
// Port-level checks of the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module uartf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tx_line_i,
  input logic push_accepted_i,
  input logic fifo_full_i,
  input logic busy_res_i
);

  // Every accepted item shows its result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result after an accepted item");

  // A byte that just entered the queue keeps the block busy.
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && push_accepted_i) |-> busy_res_i)
    else $error("accepted push without busy");

  // A full queue holds bytes, so the block reports busy.
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && fifo_full_i) |-> busy_res_i)
    else $error("full queue without busy");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(tx_line_i) && $stable(push_accepted_i)
       && $stable(fifo_full_i) && $stable(busy_res_i)))
    else $error("stalled result changed");

endmodule

bind uart_transmitter_with_fifo uartf_checker u_uartf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .tx_line_i      (out_o.tx_line),
  .push_accepted_i(out_o.push_accepted),
  .fifo_full_i    (out_o.fifo_full),
  .busy_res_i     (out_o.busy_res)
);

// ===== verif/tb_uart_transmitter_with_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_uart_transmitter_with_fifo
// Self-checking bench for the 8N1 transmitter and its byte queue. A short
// table of directed items (reset state, queue full, refused push, start bit)
// is followed by random bursts of pushes and runs of bit ticks. Every result
// item is checked against its table row or a cycle-free queue and shift model.
// ----------------------------------------------------------------------------
module tb_uart_transmitter_with_fifo;
  import uartf_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned RandomItems = 1420;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldAfter   = 500;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned MaxPrinted  = 40;

  typedef struct packed {
    logic tx_line;
    logic push_accepted;
    logic fifo_full;
    logic busy;
  } tx_result_t;

  typedef struct {
    logic        mode;
    logic [7:0]  data;
    int unsigned reps;
    logic        typed;
    tx_result_t  res;
  } dir_row_t;

  typedef struct {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    tx_result_t res;
  } tx_item_t;

  typedef enum logic [1:0] {RxAlways, RxMostly, RxSparse, RxPeriodic} rx_pattern_e;

  // Result columns are tx_line, push_accepted, fifo_full, busy.
  localparam int NumRows = 8;
  dir_row_t dir_table [NumRows] = '{
    '{ModeTick, 8'h00,  1, 1'b1, 4'b1000},  // tick on an empty queue after reset
    '{ModePush, 8'hFF,  1, 1'b1, 4'b1101},
    '{ModePush, 8'h00, 13, 1'b0, 4'b0000},
    '{ModePush, 8'h80,  1, 1'b1, 4'b1111},  // fifteenth byte fills the queue
    '{ModePush, 8'h7F,  1, 1'b1, 4'b1011},  // push into a full queue is dropped
    '{ModeTick, 8'h55,  1, 1'b1, 4'b0001},  // start bit frees one slot
    '{ModePush, 8'h01,  1, 1'b1, 4'b0111},
    '{ModeTick, 8'hAA,  9, 1'b0, 4'b0000}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  uartf_in_if  in_if ();
  uartf_out_if out_if ();

  uart_transmitter_with_fifo #(
    .FIFO_DEPTH(Depth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state of the queue and the frame in flight.
  logic [7:0]  qm_mem [Depth];
  int unsigned qm_wr    = 0;
  int unsigned qm_rd    = 0;
  logic [7:0]  qm_shift = 8'h00;
  logic [3:0]  qm_bits  = 4'd0;
  logic        qm_line  = LineIdle;

  tx_item_t    stim_q [$];
  tx_result_t  expected_q [$];
  int unsigned n_accepted     = 0;
  int unsigned n_directed     = 0;
  int unsigned err_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned frames_started = 0;
  int unsigned pushes_refused = 0;
  int unsigned hold_total     = 0;
  logic        hold_done      = 1'b0;

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= Depth) ? 0 : i + 1;
  endfunction

  function automatic tx_result_t uart_predict(logic mode, logic [7:0] data_val);
    tx_result_t r;
    r.push_accepted = 1'b0;
    if (mode == ModePush) begin
      if (next_slot(qm_wr) != qm_rd) begin
        // Bytes are held complemented so the zeros shifted in become the stop bit.
        qm_mem[qm_wr]   = ~data_val;
        qm_wr           = next_slot(qm_wr);
        r.push_accepted = 1'b1;
      end else begin
        pushes_refused++;
      end
    end else if (qm_bits != 4'd0) begin
      qm_bits  = qm_bits - 4'd1;
      qm_line  = qm_shift[0] ? LineStart : LineIdle;
      qm_shift = qm_shift >> 1;
    end else if (qm_wr != qm_rd) begin
      qm_shift = qm_mem[qm_rd];
      qm_rd    = next_slot(qm_rd);
      qm_bits  = FrameBitsAfterStart;
      qm_line  = LineStart;
      frames_started++;
    end
    r.tx_line   = qm_line;
    r.fifo_full = (next_slot(qm_wr) == qm_rd);
    r.busy      = (qm_bits != 4'd0) || (qm_wr != qm_rd);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MaxPrinted) $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_bit(string name, int unsigned idx, logic want, logic got);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s expected %b got %b", idx, name, want, got));
    end
  endtask

  function automatic void add_item(logic mode, logic [7:0] data, logic typed, tx_result_t res);
    tx_item_t it;
    it.mode  = mode;
    it.data  = data;
    it.typed = typed;
    it.res   = res;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_stimulus();
    int unsigned seg, len, total;
    foreach (dir_table[r]) begin
      for (int unsigned k = 0; k < dir_table[r].reps; k++) begin
        add_item(dir_table[r].mode, dir_table[r].data, dir_table[r].typed, dir_table[r].res);
      end
    end
    n_directed = stim_q.size();
    total = n_directed + RandomItems;
    // Bursts of pushes and runs of ticks reach full queues and whole frames;
    // the mixed and noisy segments break up the frames.
    while (stim_q.size() < total) begin
      seg = $urandom_range(0, 9);
      if (seg <= 2) begin
        len = $urandom_range(1, 18);
        repeat (len) add_item(ModePush, rand_byte(), 1'b0, '0);
      end else if (seg <= 5) begin
        len = $urandom_range(1, 40);
        repeat (len) add_item(ModeTick, rand_byte(), 1'b0, '0);
      end else if (seg == 6) begin
        repeat (160) add_item(ModeTick, rand_byte(), 1'b0, '0);
      end else if (seg <= 8) begin
        len = $urandom_range(4, 30);
        repeat (len) add_item($urandom_range(0, 3) == 0 ? ModePush : ModeTick,
                              rand_byte(), 1'b0, '0);
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) add_item(1'($urandom_range(0, 1)), rand_byte(), 1'b0, '0);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_cnt, expected_q.size());
      $display("tb_uart_transmitter_with_fifo: errors");
      $finish;
    end
  end

  // Scoreboard: the result taken at this edge belongs to an older item, so it
  // is checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin : score_proc
    tx_result_t got, want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.tx_line, out_if.push_accepted, out_if.fifo_full, out_if.busy_res};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %b", got));
        end else begin
          want = expected_q.pop_front();
          check_bit("tx_line", n_accepted, want.tx_line, got.tx_line);
          check_bit("push_accepted", n_accepted, want.push_accepted, got.push_accepted);
          check_bit("fifo_full", n_accepted, want.fifo_full, got.fifo_full);
          check_bit("busy_res", n_accepted, want.busy, got.busy);
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = uart_predict(in_if.mode, in_if.data_byte);
        if (n_accepted < stim_q.size() && stim_q[n_accepted].typed) begin
          want = stim_q[n_accepted].res;
        end
        expected_q.push_back(want);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Receiver: changing ready patterns, plus one long hold-off that backs the
  // block up while the sender keeps offering items.
  initial begin : sink_proc
    int unsigned hold_left, phase_left, tick_cnt;
    rx_pattern_e pattern;
    logic rdy;
    out_if.ready = 1'b0;
    hold_left  = 0;
    phase_left = 0;
    tick_cnt   = 0;
    pattern    = RxAlways;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      tick_cnt++;
      if (!hold_done && n_accepted >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        hold_total++;
        rdy = 1'b0;
      end else begin
        if (phase_left == 0) begin
          pattern    = rx_pattern_e'($urandom_range(0, 3));
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (pattern)
          RxAlways: rdy = 1'b1;
          RxMostly: rdy = ($urandom_range(0, 3) != 0);
          RxSparse: rdy = ($urandom_range(0, 3) == 0);
          default:  rdy = (tick_cnt % 5 != 0);
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  initial begin : drive_proc
    int unsigned burst_left, gap;
    in_if.valid     = 1'b0;
    in_if.mode      = ModePush;
    in_if.data_byte = 8'h00;
    build_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = 0;
    foreach (stim_q[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      in_if.valid     <= 1'b1;
      in_if.mode      <= stim_q[i].mode;
      in_if.data_byte <= stim_q[i].data;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
    end
    in_if.valid <= 1'b0;
    // Wait until the scoreboard has taken the last item and all its results.
    while (n_accepted < stim_q.size() || expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end
    $display("Covered %0d items (%0d directed), %0d frames started, %0d pushes refused at full.",
             n_accepted, n_directed, frames_started, pushes_refused);
    $display("Receiver held off once for %0d cycles; %0d mismatches.", hold_total, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_uart_transmitter_with_fifo: clean");
    end else begin
      $display("tb_uart_transmitter_with_fifo: errors");
    end
    $finish;
  end

endmodule
